>>> src/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types, constants and a helper function for the HSLA to RGBA converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

	// Fixed point: lightness and saturation carry FRAC_BITS fraction bits
	localparam int FRAC_BITS = 16;
	localparam int FX_W      = FRAC_BITS + 1;
	localparam int HUE_W     = 9;
	localparam int K_W       = 6;
	localparam int NUM_LANES = 3;

	localparam logic [FX_W-1:0]  ONE_FX  = FX_W'(1) << FRAC_BITS;
	localparam logic [FX_W-1:0]  HALF_FX = FX_W'(1) << (FRAC_BITS - 1);
	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;

	// Lane order inside the work item and the back end
	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;

	// floor(x/60) == (x * DIV60_RECIP) >> DIV60_SHIFT for x below 15360
	localparam logic [14:0] DIV60_RECIP = 15'd17477;
	localparam int          DIV60_SHIFT = 20;

	typedef struct packed {
		logic [HUE_W-1:0] hue_degrees;
		logic [FX_W-1:0]  saturation;
		logic [FX_W-1:0]  lightness;
		logic [7:0]       alpha_in;
	} hsla_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgba_t;

	// Transaction handed from the front end to the back end
	typedef struct packed {
		logic [FX_W-1:0]                p;
		logic [FX_W-1:0]                d;
		logic [NUM_LANES-1:0][K_W-1:0]  k;
		logic [7:0]                     alpha;
	} work_t;

	// Piecewise hue weight, 0..60, for a wrapped hue t in 0..360
	function automatic logic [K_W-1:0] hue_weight(input logic [HUE_W-1:0] t);
		logic [HUE_W-1:0] diff;
		diff = 9'd240 - t;
		if (t < 9'd60) begin
			return t[K_W-1:0];
		end else if (t < 9'd180) begin
			return 6'd60;
		end else if (t < 9'd240) begin
			return diff[K_W-1:0];
		end else begin
			return '0;
		end
	endfunction

endpackage

>>> src/hslrgb_front.sv
// ----------------------------------------------------------------------------
// hslrgb_front
// Front end: clamps the input, forms the q, p and d terms and the hue weights.
// ----------------------------------------------------------------------------
module hslrgb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hslrgb_pkg::hsla_t in_data,
	output logic            full,
	output logic            out_valid,
	input  logic            out_ready,
	output hslrgb_pkg::work_t out_data
);
	import hslrgb_pkg::*;

	logic             adv;
	logic             v_s1_q;
	logic             v_s2_q;
	logic [HUE_W-1:0] h_c;
	logic [FX_W-1:0]  s_c;
	logic [FX_W-1:0]  l_c;
	logic [2*FX_W-1:0] prod;

	logic [HUE_W-1:0] h_s1;
	logic [FX_W-1:0]  s_s1;
	logic [FX_W-1:0]  l_s1;
	logic [FX_W-1:0]  ls_s1;
	logic [7:0]       a_s1;

	logic [FX_W:0]    q_w;
	logic [FX_W:0]    p_w;
	logic [FX_W-1:0]  q;
	logic [FX_W-1:0]  p;
	logic [HUE_W:0]   t_r_w;
	logic [HUE_W:0]   t_b_w;
	logic [HUE_W-1:0] t_r;
	logic [HUE_W-1:0] t_b;
	work_t            work_s2;

	// whole front advances when its last stage is empty or drained
	assign adv       = !v_s2_q || out_ready;
	assign full      = !adv;
	assign out_valid = v_s2_q;
	assign out_data  = work_s2;

	// clamp and multiply
	always_comb begin
		h_c  = (in_data.hue_degrees > HUE_MAX) ? HUE_MAX : in_data.hue_degrees;
		s_c  = (in_data.saturation > ONE_FX) ? ONE_FX : in_data.saturation;
		l_c  = (in_data.lightness > ONE_FX) ? ONE_FX : in_data.lightness;
		prod = (2*FX_W)'(l_c) * (2*FX_W)'(s_c);
	end

	// q, p, d and wrapped hues; zero saturation falls out as p = l, d = 0
	always_comb begin
		if (l_s1 < HALF_FX) begin
			q_w = {1'b0, l_s1} + {1'b0, ls_s1};
		end else begin
			q_w = {1'b0, l_s1} + {1'b0, s_s1} - {1'b0, ls_s1};
		end
		q   = q_w[FX_W-1:0];
		p_w = {l_s1, 1'b0} - {1'b0, q};
		p   = p_w[FX_W-1:0];

		t_r_w = {1'b0, h_s1} + 10'd120;
		if (t_r_w > {1'b0, HUE_MAX}) begin
			t_r_w = t_r_w - {1'b0, HUE_MAX};
		end
		t_r = t_r_w[HUE_W-1:0];

		if (h_s1 < 9'd120) begin
			t_b_w = {1'b0, h_s1} + 10'd240;
		end else begin
			t_b_w = {1'b0, h_s1} - 10'd120;
		end
		t_b = t_b_w[HUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (adv) begin
			v_s1_q <= push;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1  <= h_c;
			s_s1  <= s_c;
			l_s1  <= l_c;
			ls_s1 <= prod[FRAC_BITS +: FX_W];
			a_s1  <= in_data.alpha_in;

			work_s2.p              <= p;
			work_s2.d              <= q - p;
			work_s2.k[LANE_RED]    <= hue_weight(t_r);
			work_s2.k[LANE_GREEN]  <= hue_weight(h_s1);
			work_s2.k[LANE_BLUE]   <= hue_weight(t_b);
			work_s2.alpha          <= a_s1;
		end
	end

endmodule

>>> src/hslrgb_fifo.sv
// ----------------------------------------------------------------------------
// hslrgb_fifo
// Small decoupling queue between the front and back ends.
// ----------------------------------------------------------------------------
module hslrgb_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hslrgb_pkg::work_t wdata,
	output logic              full,
	input  logic              pop,
	output hslrgb_pkg::work_t rdata,
	output logic              empty
);
	import hslrgb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	work_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> src/hslrgb_back.sv
// ----------------------------------------------------------------------------
// hslrgb_back
// Back end: three channel lanes, blend, scale by 255, divide by 60.
// ----------------------------------------------------------------------------
module hslrgb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hslrgb_pkg::work_t in_data,
	output logic              empty,
	input  logic              pop,
	output hslrgb_pkg::rgba_t out_data
);
	import hslrgb_pkg::*;

	localparam int M_W = FX_W + 5;      // 60 * ONE fits
	localparam int P_W = M_W + 8;       // times 255
	localparam int X_W = P_W - FRAC_BITS;
	localparam int Y_W = X_W + 15;

	logic adv;
	logic v_b1_q;
	logic v_b2_q;
	logic v_b3_q;

	logic [NUM_LANES-1:0][M_W-1:0] m_c;
	logic [NUM_LANES-1:0][M_W-1:0] m_b1;
	logic [NUM_LANES-1:0][P_W-1:0] sc_c;
	logic [NUM_LANES-1:0][X_W-1:0] x_b2;
	logic [NUM_LANES-1:0][Y_W-1:0] y_c;
	logic [NUM_LANES-1:0][7:0]     ch_b3;
	logic [7:0]                    a_b1;
	logic [7:0]                    a_b2;
	logic [7:0]                    a_b3;

	assign adv      = !v_b3_q || pop;
	assign in_ready = adv;
	assign empty    = !v_b3_q;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			m_c[i]  = M_W'(in_data.p) * M_W'(60) + M_W'(in_data.d) * M_W'(in_data.k[i]);
			sc_c[i] = {m_b1[i], 8'b0} - P_W'(m_b1[i]);
			y_c[i]  = Y_W'(x_b2[i]) * Y_W'(DIV60_RECIP);
		end
	end

	assign out_data.red       = ch_b3[LANE_RED];
	assign out_data.green     = ch_b3[LANE_GREEN];
	assign out_data.blue      = ch_b3[LANE_BLUE];
	assign out_data.alpha_out = a_b3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1_q <= 1'b0;
			v_b2_q <= 1'b0;
			v_b3_q <= 1'b0;
		end else if (adv) begin
			v_b1_q <= in_valid;
			v_b2_q <= v_b1_q;
			v_b3_q <= v_b2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_b1 <= in_data.alpha;
			a_b2 <= a_b1;
			a_b3 <= a_b2;
			for (int i = 0; i < NUM_LANES; i++) begin
				m_b1[i]  <= m_c[i];
				x_b2[i]  <= sc_c[i][P_W-1:FRAC_BITS];
				ch_b3[i] <= y_c[i][DIV60_SHIFT +: 8];
			end
		end
	end

endmodule

>>> src/hsla_to_rgba_converter_core.sv
// ----------------------------------------------------------------------------
// hsla_to_rgba_converter_core
// HSLA color to 8-bit RGBA, one transaction per clock while neither side stalls.
// ----------------------------------------------------------------------------
//  channel   | ports                      | transaction on
//  ----------+----------------------------+----------------------------
//  input     | push, full, color_in       | push && !full
//  result    | pop, empty, color_out      | pop && !empty
//
//  Sustained rate: one transaction per cycle in and out when nothing stalls.
//  Path: front stages s1, s2, then the queue, then back stages b1, b2, b3;
//  the back end's three lanes share no unit.
//  Reset (arst_n low) empties all stages and the queue; data regs not reset.
//  A held result stalls only the back end; the queue (QUEUE_DEPTH entries)
//  absorbs it before the front end raises full.
// ----------------------------------------------------------------------------
module hsla_to_rgba_converter_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hslrgb_pkg::hsla_t color_in,
	input  logic              pop,
	output logic              empty,
	output hslrgb_pkg::rgba_t color_out
);
	import hslrgb_pkg::*;

	// front end -> queue
	logic  fr_valid;
	logic  q_full;
	work_t fr_work;

	// queue -> back end
	logic  q_empty;
	logic  bk_ready;
	work_t q_work;

	// Front: clamp, q/p/d terms, per-channel hue weights
	hslrgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_data   (color_in),
		.full      (full),
		.out_valid (fr_valid),
		.out_ready (!q_full),
		.out_data  (fr_work)
	);

	// Decoupling queue so each side stalls on its own
	hslrgb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_valid),
		.wdata  (fr_work),
		.full   (q_full),
		.pop    (bk_ready),
		.rdata  (q_work),
		.empty  (q_empty)
	);

	// Back: blend, scale by 255, divide by 60 (reciprocal multiply)
	hslrgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.in_ready (bk_ready),
		.in_data  (q_work),
		.empty    (empty),
		.pop      (pop),
		.out_data (color_out)
	);

endmodule
